// ===== hdl/iafd_pkg.sv =====
package iafd_pkg;

  // frame layout
  localparam logic [7:0] FRAME_HEADER  = 8'hAA;
  localparam logic [7:0] FRAME_TRAILER = 8'h55;
  localparam int unsigned DATA_BYTES   = 6;
  localparam logic [2:0] POS_HUNT      = 3'd0;
  localparam logic [2:0] POS_LAST      = 3'd7;

  // word / 100 as (word * DIV_MULT) >> DIV_SHIFT, exact for all 16-bit words
  localparam int unsigned DIV_SHIFT    = 23;
  localparam logic [16:0] DIV_MULT     = 17'd83887;

  // angle folding thresholds
  localparam logic [9:0] ANGLE_DIRECT_MAX = 10'd179;
  localparam logic [9:0] ANGLE_FOLD_MAX   = 10'd475;
  localparam logic [9:0] ANGLE_FOLD_BASE  = 10'd655;
  localparam logic [9:0] ANGLE_WRAP_OFS   = 10'd295;

  typedef logic [DATA_BYTES-1:0][7:0] frame_data_t;
  typedef logic [8:0]                 angle_t;

endpackage

// ===== hdl/iafd_framer.sv =====
module iafd_framer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rx_vld,
  input  logic [7:0]            rx_byte,
  output logic                  frame_hit,
  output iafd_pkg::frame_data_t frame_data
);

  logic [2:0]            pos_r;
  logic [2:0]            pos_nxt;
  iafd_pkg::frame_data_t data_r;

  always_comb begin
    pos_nxt = pos_r;
    if (rx_vld) begin
      if (pos_r == iafd_pkg::POS_HUNT) begin
        if (rx_byte == iafd_pkg::FRAME_HEADER) begin
          pos_nxt = pos_r + 3'd1;
        end
      end else if (pos_r == iafd_pkg::POS_LAST) begin
        pos_nxt = iafd_pkg::POS_HUNT;
      end else begin
        pos_nxt = pos_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= iafd_pkg::POS_HUNT;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // data bytes land at position - 1
  always_ff @(posedge clk) begin
    for (int i = 0; i < iafd_pkg::DATA_BYTES; i++) begin
      if (rx_vld && pos_r == 3'(i + 1)) begin
        data_r[i] <= rx_byte;
      end
    end
  end

  // good trailer on the presented byte; the caller qualifies it with its valid
  assign frame_hit  = (pos_r == iafd_pkg::POS_LAST) &&
                      (rx_byte == iafd_pkg::FRAME_TRAILER);
  assign frame_data = data_r;

  a_hunt_stays: assert property (@(posedge clk) disable iff (!rst_n)
    rx_vld && pos_r == iafd_pkg::POS_HUNT && rx_byte != iafd_pkg::FRAME_HEADER
    |=> pos_r == iafd_pkg::POS_HUNT)
    else $error("framer left hunt without header");

  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    rx_vld && pos_r == iafd_pkg::POS_LAST |=> pos_r == iafd_pkg::POS_HUNT)
    else $error("framer did not return to hunt after last byte");

  a_mid_advance: assert property (@(posedge clk) disable iff (!rst_n)
    rx_vld && pos_r != iafd_pkg::POS_HUNT && pos_r != iafd_pkg::POS_LAST
    |=> pos_r == $past(pos_r) + 3'd1)
    else $error("framer position did not advance mid-frame");

endmodule

// ===== hdl/iafd_angle.sv =====
module iafd_angle (
  input  logic [7:0]       word_hi,
  input  logic [7:0]       word_lo,
  output iafd_pkg::angle_t angle
);

  logic [15:0] word;
  logic [32:0] prod;
  logic [9:0]  raw;
  logic [9:0]  folded;

  assign word = {word_hi, word_lo};
  // reciprocal multiply, truncating divide by 100
  assign prod = {17'd0, word} * {16'd0, iafd_pkg::DIV_MULT};
  assign raw  = prod[iafd_pkg::DIV_SHIFT +: 10];

  always_comb begin
    if (raw <= iafd_pkg::ANGLE_DIRECT_MAX) begin
      folded = raw;
    end else if (raw <= iafd_pkg::ANGLE_FOLD_MAX) begin
      folded = iafd_pkg::ANGLE_FOLD_BASE - raw;
    end else if (raw == iafd_pkg::ANGLE_FOLD_BASE) begin
      folded = 10'd0;
    end else begin
      // negated fold plus a full turn
      folded = raw - iafd_pkg::ANGLE_WRAP_OFS;
    end
  end

  assign angle = folded[8:0];

endmodule

// ===== hdl/imu_angle_frame_decoder.sv =====
// imu angle frame decoder
//
// input channel: one serial link byte per transfer on in_rx_byte, valid/ready.
// frames are 8 bytes: header 0xAA, three big-endian 16-bit words (yaw,
// pitch, roll), trailer 0x55. bytes outside a frame are dropped while
// hunting for the header; a header value inside a frame is plain data.
// output channel: one word of yaw/pitch/roll in whole degrees per frame
// with a good trailer; a bad trailer gives nothing.
// throughput: one byte per cycle, set by the single input register stage,
// unless a stalled result blocks it. an accepted trailer byte passes the
// input register, and its result is presented from the output register.
// when the receiver stalls, the result holds in the output register and
// the input register still drains bytes that give no result; a second
// result waits in the input register, and only then does in_ready drop.
// reset (rst_n low, synchronous) empties both registers and restarts the
// header hunt; the stored frame data needs no reset.
module imu_angle_frame_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [8:0] out_yaw_deg,
  output logic [8:0] out_pitch_deg,
  output logic [8:0] out_roll_deg
);

  // input register
  logic                  in_vld_r;
  logic [7:0]            in_byte_r;
  // framer interface
  logic                  stage_adv;
  logic                  frame_hit;
  iafd_pkg::frame_data_t frame_data;
  // decoded angles
  iafd_pkg::angle_t      yaw_nxt;
  iafd_pkg::angle_t      pitch_nxt;
  iafd_pkg::angle_t      roll_nxt;
  // output register
  logic                  out_vld_r;
  iafd_pkg::angle_t      yaw_r;
  iafd_pkg::angle_t      pitch_r;
  iafd_pkg::angle_t      roll_r;
  logic                  out_free;
  logic                  stage_hit;

  // output register can take a new word this cycle
  assign out_free  = !out_vld_r || out_ready;

  // stage word is a good trailer if it would finish a frame
  assign stage_hit = frame_hit;

  // stage moves on unless it holds a result and the output is full
  assign stage_adv = in_vld_r && (!stage_hit || out_free);
  assign in_ready  = !in_vld_r || stage_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // framer sees only bytes that leave the stage, so a stalled trailer
  // is not counted twice
  iafd_framer u_framer (
    .clk        (clk),
    .rst_n      (rst_n),
    .rx_vld     (stage_adv),
    .rx_byte    (in_byte_r),
    .frame_hit  (frame_hit),
    .frame_data (frame_data)
  );

  iafd_angle u_yaw (
    .word_hi (frame_data[0]),
    .word_lo (frame_data[1]),
    .angle   (yaw_nxt)
  );

  iafd_angle u_pitch (
    .word_hi (frame_data[2]),
    .word_lo (frame_data[3]),
    .angle   (pitch_nxt)
  );

  iafd_angle u_roll (
    .word_hi (frame_data[4]),
    .word_lo (frame_data[5]),
    .angle   (roll_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= stage_adv && stage_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && stage_adv && stage_hit) begin
      yaw_r   <= yaw_nxt;
      pitch_r <= pitch_nxt;
      roll_r  <= roll_nxt;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_yaw_deg   = yaw_r;
  assign out_pitch_deg = pitch_r;
  assign out_roll_deg  = roll_r;

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (yaw_r <= 9'd475) && (pitch_r <= 9'd475) && (roll_r <= 9'd475))
    else $error("decoded angle out of range");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !stage_adv |=> in_vld_r && $stable(in_byte_r))
    else $error("input stage lost a blocked byte");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(stage_adv && stage_hit))
    else $error("result appeared without a finished frame");

endmodule
